// ----- rtl/mqtt_pkg.sv -----
// ----------------------------------------------------------------------------
// MQTT deframer package
// Shared types and constants for the receive-side MQTT fixed-header deframer.
// ----------------------------------------------------------------------------
package mqtt_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 28;
  localparam int CNT_W  = 16;
  localparam int TLIM_W = 11;

  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  typedef enum logic [2:0] {
    ROLE_TYPE      = 3'd0,
    ROLE_LENGTH    = 3'd1,
    ROLE_TOPIC_LEN = 3'd2,
    ROLE_TOPIC     = 3'd3,
    ROLE_PAYLOAD   = 3'd4,
    ROLE_DROPPED   = 3'd5,
    ROLE_OTHER     = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CONN_OK   = 3'd1,
    EV_CONN_REF  = 3'd2,
    EV_INVALID   = 3'd3,
    EV_PUBLISH   = 3'd4,
    EV_PINGRESP  = 3'd5,
    EV_OTHER     = 3'd6,
    EV_MALFORMED = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  localparam logic [1:0] REG_TOPIC_LIMIT   = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd1;

  // One classified word travelling from the parser to the output stage.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    role_t             byte_role;
    logic [3:0]        packet_type;
    logic              packet_end;
    event_t            event_code;
    logic [BYTE_W-1:0] return_code;
    logic [LEN_W-1:0]  remaining_length;
    logic [CNT_W-1:0]  payload_count;
    logic              link_up;
  } result_t;

endpackage

// ----- rtl/mqtt_parse.sv -----
// ----------------------------------------------------------------------------
// MQTT deframer front end
// Accepts one byte per cycle while step is high, tracks the fixed header and body, tags roles.
// ----------------------------------------------------------------------------
module mqtt_parse import mqtt_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [TLIM_W-1:0] topic_limit,
  input  logic [CNT_W-1:0]  payload_limit,
  output result_t           res
);

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] type_byte, type_byte_next;
  logic [LEN_W-1:0]  length_value, length_value_next;
  logic [2:0]        len_cnt, len_cnt_next;
  logic [LEN_W-1:0]  body_count, body_count_next;
  logic [CNT_W-1:0]  topic_length, topic_length_next;
  logic [CNT_W-1:0]  kept, kept_next;
  logic [BYTE_W-1:0] ack_code, ack_code_next;
  logic              bad, bad_next;
  logic              conn, conn_next;

  logic [3:0]        ptype;
  logic [LEN_W-1:0]  shifted;
  logic [CNT_W-1:0]  cap;
  logic [LEN_W:0]    topic_end;
  logic              finish;

  assign ptype = type_byte[7:4];
  assign cap   = (payload_limit == '0) ? '0 : payload_limit - 1'b1;

  always_comb begin
    shifted = '0;
    case (len_cnt[1:0])
      2'd0: shifted = LEN_W'(rx_byte[6:0]);
      2'd1: shifted = LEN_W'({rx_byte[6:0], 7'd0});
      2'd2: shifted = LEN_W'({rx_byte[6:0], 14'd0});
      default: shifted = {rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_next        = phase;
    type_byte_next    = type_byte;
    length_value_next = length_value;
    len_cnt_next      = len_cnt;
    body_count_next   = body_count;
    topic_length_next = topic_length;
    kept_next         = kept;
    ack_code_next     = ack_code;
    bad_next          = bad;
    conn_next         = conn;
    finish            = 1'b0;
    topic_end         = (LEN_W+1)'(topic_length) + (LEN_W+1)'(2);
    res               = '0;
    res.data_byte     = rx_byte;
    res.byte_role     = ROLE_TYPE;
    unique case (phase)
      PH_LEN: begin
        res.byte_role = ROLE_LENGTH;
        if (len_cnt < 3'd4) begin
          length_value_next = length_value + shifted;
        end
        len_cnt_next = len_cnt + 3'd1;
        if (!rx_byte[7]) begin
          if (length_value_next == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end else if (len_cnt_next >= 3'(MAX_LENGTH_BYTES)) begin
          res.packet_end = 1'b1;
          res.event_code = EV_MALFORMED;
          phase_next     = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (ptype == TYPE_PUBLISH) begin
          if (body_count < LEN_W'(2)) begin
            res.byte_role     = ROLE_TOPIC_LEN;
            topic_length_next = {topic_length[7:0], rx_byte};
            if (body_count == LEN_W'(1)) begin
              bad_next = (topic_length_next >= CNT_W'(topic_limit)) ||
                ((LEN_W+1)'(topic_length_next) + (LEN_W+1)'(2) >
                 (LEN_W+1)'(length_value));
            end
          end else if ((LEN_W+1)'(body_count) < topic_end) begin
            res.byte_role = ROLE_TOPIC;
          end else if (kept < cap) begin
            res.byte_role = ROLE_PAYLOAD;
            kept_next     = kept + 1'b1;
          end else begin
            res.byte_role = ROLE_DROPPED;
          end
        end else begin
          res.byte_role = ROLE_OTHER;
          if (ptype == TYPE_CONNACK && body_count == LEN_W'(1)) begin
            ack_code_next = rx_byte;
          end
        end
        body_count_next = body_count + 1'b1;
        if (body_count_next >= length_value) begin
          finish = 1'b1;
        end
      end
      default: begin
        type_byte_next    = rx_byte;
        length_value_next = '0;
        len_cnt_next      = '0;
        body_count_next   = '0;
        topic_length_next = '0;
        kept_next         = '0;
        ack_code_next     = '0;
        bad_next          = 1'b0;
        phase_next        = PH_LEN;
      end
    endcase
    if (finish) begin
      res.packet_end = 1'b1;
      phase_next     = PH_IDLE;
      if (ptype == TYPE_CONNACK) begin
        if (length_value_next < LEN_W'(2)) begin
          res.event_code = EV_INVALID;
        end else if (ack_code_next == '0) begin
          res.event_code = EV_CONN_OK;
          conn_next      = 1'b1;
        end else begin
          res.event_code  = EV_CONN_REF;
          res.return_code = ack_code_next;
          conn_next       = 1'b0;
        end
      end else if (ptype == TYPE_PUBLISH) begin
        if (length_value_next < LEN_W'(2) || bad_next) begin
          res.event_code = EV_INVALID;
        end else begin
          res.event_code    = EV_PUBLISH;
          res.payload_count = kept_next;
        end
      end else if (ptype == TYPE_PINGRESP) begin
        res.event_code = EV_PINGRESP;
      end else begin
        res.event_code = EV_OTHER;
      end
    end
    res.packet_type      = type_byte_next[7:4];
    res.remaining_length = length_value_next;
    res.link_up          = conn_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      type_byte    <= '0;
      length_value <= '0;
      len_cnt      <= '0;
      body_count   <= '0;
      topic_length <= '0;
      kept         <= '0;
      ack_code     <= '0;
      bad          <= 1'b0;
      conn         <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      type_byte    <= type_byte_next;
      length_value <= length_value_next;
      len_cnt      <= len_cnt_next;
      body_count   <= body_count_next;
      topic_length <= topic_length_next;
      kept         <= kept_next;
      ack_code     <= ack_code_next;
      bad          <= bad_next;
      conn         <= conn_next;
    end
  end

endmodule

// ----- rtl/mqtt_fifo.sv -----
// ----------------------------------------------------------------------------
// MQTT deframer result queue
// Two-entry queue that decouples the parser from the output handshake.
// ----------------------------------------------------------------------------
module mqtt_fifo import mqtt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    not_empty,
  input  logic    pop,
  output result_t head
);

  result_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/mqtt_rx_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// MQTT receive packet deframer
// Tags each received MQTT byte with its role and reports packet-end events.
// ----------------------------------------------------------------------------
// The block takes one broker stream byte per word on the input channel and
// returns exactly one result word per byte, in order. A byte is parsed in the
// cycle it is accepted, so a new byte can be taken every cycle; the parse
// result goes into a two-entry queue that feeds the output ports, so a stall
// on the output side only holds off input once that queue is full. The
// two limit registers sit on an APB-style port at byte addresses 0 and 4 and
// should only be written while no bytes are in flight.
module mqtt_rx_packet_deframer_top import mqtt_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    data_byte,
  output logic [2:0]           byte_role,
  output logic [3:0]           packet_type,
  output logic                 packet_end,
  output logic [2:0]           event_code,
  output logic [BYTE_W-1:0]    return_code,
  output logic [LEN_W-1:0]     remaining_length,
  output logic [CNT_W-1:0]     payload_count,
  output logic                 link_up
);

  logic [TLIM_W-1:0] topic_limit;
  logic [CNT_W-1:0]  payload_limit;
  logic              step, full;
  result_t           parsed, head;

  // Register file: writes land on the access phase.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      topic_limit   <= TLIM_W'(128);
      payload_limit <= CNT_W'(256);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TOPIC_LIMIT[0]:   topic_limit   <= pwdata[TLIM_W-1:0];
        REG_PAYLOAD_LIMIT[0]: payload_limit <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAYLOAD_LIMIT[0]) begin
      prdata = 32'(payload_limit);
    end else begin
      prdata = 32'(topic_limit);
    end
  end

  // Input is held off only while the result queue has no room.
  assign in_stall = full;
  assign step     = in_valid && !full;

  mqtt_parse #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_parse (
    .clk(clk), .rst(rst), .step(step), .rx_byte(rx_byte),
    .topic_limit(topic_limit), .payload_limit(payload_limit), .res(parsed)
  );

  mqtt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(step), .push_data(parsed), .full(full),
    .not_empty(out_valid), .pop(out_valid && !out_stall), .head(head)
  );

  assign data_byte        = head.data_byte;
  assign byte_role        = head.byte_role;
  assign packet_type      = head.packet_type;
  assign packet_end       = head.packet_end;
  assign event_code       = head.event_code;
  assign return_code      = head.return_code;
  assign remaining_length = head.remaining_length;
  assign payload_count    = head.payload_count;
  assign link_up          = head.link_up;

endmodule

// ----- rtl/mqtt_checker.sv -----
// ----------------------------------------------------------------------------
// MQTT deframer port checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mqtt_checker import mqtt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic [2:0] byte_role,
  input logic       packet_end,
  input logic [2:0] event_code
);

  // Events only ride on the word that ends a packet.
  a_event_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_end |-> event_code == EV_NONE)
    else $error("event without packet end");

  a_end_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> event_code != EV_NONE)
    else $error("packet end without event");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte))
    else $error("stalled word changed");

  // A type byte never ends a packet.
  a_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_TYPE |-> !packet_end)
    else $error("type byte ended packet");

endmodule

bind mqtt_rx_packet_deframer_top mqtt_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .data_byte(data_byte), .byte_role(byte_role), .packet_end(packet_end),
  .event_code(event_code)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// MQTT deframer testbench
// Streams MQTT byte sequences through the deframer and checks every tagged
// result word against a cycle-free model of the parser kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import mqtt_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_byte;
  logic [2:0]  byte_role;
  logic [3:0]  packet_type;
  logic        packet_end;
  logic [2:0]  event_code;
  logic [7:0]  return_code;
  logic [27:0] remaining_length;
  logic [15:0] payload_count;
  logic        link_up;

  mqtt_rx_packet_deframer_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_byte(data_byte), .byte_role(byte_role), .packet_type(packet_type),
    .packet_end(packet_end), .event_code(event_code), .return_code(return_code),
    .remaining_length(remaining_length), .payload_count(payload_count),
    .link_up(link_up)
  );

  // Clock with period 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  localparam int CYCLE_LIMIT = 400000;

  // Model state for the parser, mirroring the block's registers.
  logic [10:0] topic_lim;
  logic [15:0] payload_lim;
  phase_t      phase;
  logic [7:0]  hdr_byte;
  logic [27:0] rem_len;
  logic [2:0]  len_bytes;
  logic [27:0] body_cnt;
  logic [15:0] topic_len;
  logic [15:0] kept;
  logic [7:0]  ack;
  logic        bad_pkt;
  logic        connected;

  result_t     expected_words[$];
  logic [7:0]  pending_bytes[$];
  int          errors;
  int          cycles;
  logic        hold_off;     // Long receiver hold-off requested by the stimulus.
  int          hold_count;
  int          gap_left;
  int          burst_left;

  task automatic model_reset();
    topic_lim   = 11'd128;
    payload_lim = 16'd256;
    phase       = PH_IDLE;
    hdr_byte    = '0;
    rem_len     = '0;
    len_bytes   = '0;
    body_cnt    = '0;
    topic_len   = '0;
    kept        = '0;
    ack         = '0;
    bad_pkt     = 1'b0;
    connected   = 1'b0;
  endtask

  // Closes the current packet and fills in the event fields.
  function automatic void close_packet(inout result_t r);
    logic [3:0] t;
    t = hdr_byte[7:4];
    r.packet_end = 1'b1;
    if (t == TYPE_CONNACK) begin
      if (rem_len < 2) begin
        r.event_code = EV_INVALID;
      end else if (ack == 8'd0) begin
        r.event_code = EV_CONN_OK;
        connected = 1'b1;
      end else begin
        r.event_code = EV_CONN_REF;
        r.return_code = ack;
        connected = 1'b0;
      end
    end else if (t == TYPE_PUBLISH) begin
      if (rem_len < 2 || bad_pkt) begin
        r.event_code = EV_INVALID;
      end else begin
        r.event_code = EV_PUBLISH;
        r.payload_count = kept;
      end
    end else if (t == TYPE_PINGRESP) begin
      r.event_code = EV_PINGRESP;
    end else begin
      r.event_code = EV_OTHER;
    end
    phase = PH_IDLE;
  endfunction

  // Parses one byte and returns the word that the block should produce.
  function automatic result_t parse_byte(logic [7:0] b);
    result_t    r;
    logic [3:0] t;
    logic [15:0] cap;
    r = '0;
    r.data_byte = b;
    t = hdr_byte[7:4];
    if (phase == PH_LEN) begin
      r.byte_role = ROLE_LENGTH;
      if (len_bytes < 4)
        rem_len = rem_len + (28'(b[6:0]) << (7 * len_bytes));
      len_bytes = len_bytes + 3'd1;
      if (!b[7]) begin
        if (rem_len == 0)
          close_packet(r);
        else
          phase = PH_BODY;
      end else if (len_bytes >= 4) begin
        r.packet_end = 1'b1;
        r.event_code = EV_MALFORMED;
        phase = PH_IDLE;
      end
    end else if (phase == PH_BODY) begin
      if (t == TYPE_PUBLISH) begin
        if (body_cnt < 2) begin
          r.byte_role = ROLE_TOPIC_LEN;
          topic_len = {topic_len[7:0], b};
          if (body_cnt == 1)
            bad_pkt = (topic_len >= 16'(topic_lim)) ||
                      (29'(topic_len) + 29'd2 > 29'(rem_len));
        end else if (29'(body_cnt) < 29'd2 + 29'(topic_len)) begin
          r.byte_role = ROLE_TOPIC;
        end else begin
          cap = (payload_lim != 0) ? payload_lim - 16'd1 : 16'd0;
          if (kept < cap) begin
            r.byte_role = ROLE_PAYLOAD;
            kept = kept + 16'd1;
          end else begin
            r.byte_role = ROLE_DROPPED;
          end
        end
      end else begin
        r.byte_role = ROLE_OTHER;
        if (t == TYPE_CONNACK && body_cnt == 1)
          ack = b;
      end
      body_cnt = body_cnt + 28'd1;
      if (body_cnt >= rem_len)
        close_packet(r);
    end else begin
      r.byte_role = ROLE_TYPE;
      hdr_byte  = b;
      rem_len   = '0;
      len_bytes = '0;
      body_cnt  = '0;
      topic_len = '0;
      kept      = '0;
      ack       = '0;
      bad_pkt   = 1'b0;
      phase     = PH_LEN;
    end
    r.packet_type = hdr_byte[7:4];
    r.remaining_length = rem_len;
    r.link_up = connected;
    return r;
  endfunction

  // Driver: pops pending bytes in bursts separated by random gaps. The
  // expectation is computed at the moment a word is accepted, and the byte
  // on the port stays at the head of the queue until then.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(parse_byte(rx_byte));
        void'(pending_bytes.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the stalled word steady.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() > 0) begin
        rx_byte <= pending_bytes[0];
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: long hold-offs on request, otherwise random
  // stretches of stalling mixed with stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_off && hold_count < 60) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (cycles[8]) begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      out_stall <= 1'b0;
      if (!hold_off)
        hold_count <= 0;
    end
  end

  // Monitor: compares every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word data_byte=%h", $time, data_byte);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (data_byte !== e.data_byte) begin
          $display("%0t: data_byte exp %h got %h", $time, e.data_byte, data_byte);
          errors++;
        end
        if (byte_role !== e.byte_role) begin
          $display("%0t: byte_role exp %0d got %0d", $time, e.byte_role, byte_role);
          errors++;
        end
        if (packet_type !== e.packet_type) begin
          $display("%0t: packet_type exp %0d got %0d", $time, e.packet_type, packet_type);
          errors++;
        end
        if (packet_end !== e.packet_end) begin
          $display("%0t: packet_end exp %0d got %0d", $time, e.packet_end, packet_end);
          errors++;
        end
        if (event_code !== e.event_code) begin
          $display("%0t: event_code exp %0d got %0d", $time, e.event_code, event_code);
          errors++;
        end
        if (return_code !== e.return_code) begin
          $display("%0t: return_code exp %h got %h", $time, e.return_code, return_code);
          errors++;
        end
        if (remaining_length !== e.remaining_length) begin
          $display("%0t: remaining_length exp %0d got %0d", $time,
                   e.remaining_length, remaining_length);
          errors++;
        end
        if (payload_count !== e.payload_count) begin
          $display("%0t: payload_count exp %0d got %0d", $time,
                   e.payload_count, payload_count);
          errors++;
        end
        if (link_up !== e.link_up) begin
          $display("%0t: link_up exp %0d got %0d", $time, e.link_up, link_up);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Writes one limit register through the APB port.
  task automatic write_limit(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 1'b0} << 1;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TOPIC_LIMIT)
      topic_lim = value[10:0];
    else
      payload_lim = value[15:0];
  endtask

  // Waits until every queued byte has been sent and every word returned.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Appends a varint remaining length; extra continuation bytes are allowed.
  task automatic put_length(int unsigned len);
    do begin
      pending_bytes.push_back({(len > 127) ? 1'b1 : 1'b0, 7'(len)});
      len = len >> 7;
    end while (len != 0);
  endtask

  // Appends one packet with a well-formed length field, of a chosen type with random content.
  task automatic put_packet(logic [3:0] t, int unsigned body);
    int unsigned tl;
    pending_bytes.push_back({t, 4'($urandom)});
    put_length(body);
    if (t == TYPE_CONNACK && body >= 2) begin
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom));
      for (int i = 2; i < body; i++) pending_bytes.push_back(8'($urandom));
    end else if (t == TYPE_PUBLISH && body >= 2) begin
      tl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, body - 2);
      pending_bytes.push_back(tl[15:8]);
      pending_bytes.push_back(tl[7:0]);
      for (int i = 2; i < body; i++) pending_bytes.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < body; i++) pending_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned sel;
    logic [3:0]  t;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
    model_reset();
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: CONNACK, PINGRESP, PUBLISH and other types, zero length,
    // malformed length, short and refused CONNACK, bad topic and all-ones bytes.
    put_packet(TYPE_CONNACK, 2);
    put_packet(TYPE_PINGRESP, 0);
    pending_bytes.push_back(8'hFF);
    put_length(32'hFFFFFFFF);
    put_packet(TYPE_CONNACK, 1);
    pending_bytes.push_back(8'h20);
    pending_bytes.push_back(8'h02);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h30);
    pending_bytes.push_back(8'h05);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h07);
    pending_bytes.push_back(8'h41);
    pending_bytes.push_back(8'h42);
    pending_bytes.push_back(8'h43);
    put_packet(4'd0, 1);
    drain();

    // Sweep the limit settings, extremes included.
    for (int phase_i = 0; phase_i < 6; phase_i++) begin
      case (phase_i)
        0: begin
          write_limit(REG_TOPIC_LIMIT, 32'd1);
          write_limit(REG_PAYLOAD_LIMIT, 32'd1);
        end
        1: begin
          write_limit(REG_TOPIC_LIMIT, 32'd1024);
          write_limit(REG_PAYLOAD_LIMIT, 32'd65535);
        end
        2: begin
          write_limit(REG_TOPIC_LIMIT, 32'hFFFFF800);
          write_limit(REG_PAYLOAD_LIMIT, 32'hFFFF0000);
        end
        3: begin
          write_limit(REG_TOPIC_LIMIT, 32'd3);
          write_limit(REG_PAYLOAD_LIMIT, 32'd4);
        end
        default: begin
          write_limit(REG_TOPIC_LIMIT, $urandom_range(1, 2047));
          write_limit(REG_PAYLOAD_LIMIT, $urandom_range(1, 20));
        end
      endcase
      n = 0;
      while (n < 175) begin
        sel = $urandom_range(0, 19);
        t = (sel < 7) ? TYPE_PUBLISH : (sel < 11) ? TYPE_CONNACK
          : (sel < 13) ? TYPE_PINGRESP : 4'($urandom);
        if (sel == 19) begin
          pending_bytes.push_back(8'($urandom));
          pending_bytes.push_back(8'h80 | 8'($urandom));
          pending_bytes.push_back(8'h80 | 8'($urandom));
          pending_bytes.push_back(8'h80 | 8'($urandom));
          pending_bytes.push_back(8'($urandom));
        end else begin
          put_packet(t, ($urandom_range(0, 9) == 0) ? $urandom_range(128, 140)
                                                     : $urandom_range(0, 12));
        end
        n = pending_bytes.size() + n;
        // Ask for a long output hold-off while the sender keeps going.
        if (phase_i == 1 && n > 80 && !hold_off)
          hold_off = 1'b1;
        drain_partial: while (pending_bytes.size() > 40) @(posedge clk);
        n = n - pending_bytes.size();
      end
      hold_off = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
